FILE: rtl/dfm_pkg.sv
// Shared types and constants for the debounced fault monitor.
// No dependencies; every other file in rtl/ except dfm_stream_if imports this package.
package dfm_pkg;

  localparam int unsigned CNT_W = 8;
  localparam int unsigned NUM_CHANS = 5;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_W = 16;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam int unsigned DEBOUNCE_TICKS = 50;
  localparam int unsigned OVP_RELEASE_TICKS = 200;

  // Thermistor window, fixed
  localparam logic [11:0] NTC_FAULT_HIGH = 12'd4050;
  localparam logic [11:0] NTC_FAULT_LOW = 12'd50;
  localparam logic [11:0] NTC_OK_HIGH = 12'd3850;
  localparam logic [11:0] NTC_OK_LOW = 12'd150;

  // Register indexes
  localparam logic [2:0] REG_HOT_ERR_ON = 3'd0;
  localparam logic [2:0] REG_HOT_ERR_OFF = 3'd1;
  localparam logic [2:0] REG_HOT_WARN_ON = 3'd2;
  localparam logic [2:0] REG_HOT_WARN_OFF = 3'd3;
  localparam logic [2:0] REG_OVOLT_ON = 3'd4;
  localparam logic [2:0] REG_OVOLT_OFF = 3'd5;
  localparam logic [2:0] REG_OCURR_ON = 3'd6;
  localparam logic [2:0] REG_OCURR_OFF = 3'd7;

  localparam logic [REG_W-1:0] THR_ON_RESET = 16'hFFFF;
  localparam logic [REG_W-1:0] THR_OFF_RESET = 16'h0000;

  typedef struct packed {
    logic [11:0] ntc_raw;
    logic [15:0] temperature;
    logic [15:0] out_voltage;
    logic [15:0] out_current;
  } in_item_t;

  typedef struct packed {
    logic sensor_fault;
    logic hot_error;
    logic hot_warning;
    logic over_voltage;
    logic over_current;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] hot_error_on;
    logic [REG_W-1:0] hot_error_off;
    logic [REG_W-1:0] hot_warn_on;
    logic [REG_W-1:0] hot_warn_off;
    logic [REG_W-1:0] overvolt_on;
    logic [REG_W-1:0] overvolt_off;
    logic [REG_W-1:0] overcurr_on;
    logic [REG_W-1:0] overcurr_off;
  } cfg_t;

  // Run conditions for one channel on the current beat
  typedef struct packed {
    logic set_hit;
    logic clr_hit;
  } chan_cond_t;

endpackage

FILE: rtl/dfm_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
// Depends on nothing; the payload type is set per instance.
interface dfm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/debounced_fault_monitor.sv
// Top level of the debounced fault monitor: sample register, five debounced
// hysteresis channels, result register and APB threshold registers.
// Depends on dfm_pkg, dfm_stream_if, dfm_apb_regs and dfm_channel.
//
//   Channel   Dir  Protocol      Beat contents
//   in_i      in   valid/ready   ntc_raw, temperature, out_voltage, out_current
//   out_o     out  valid/ready   sensor_fault, hot_error, hot_warning,
//                                over_voltage, over_current
//   APB       in   psel/penable  eight 16-bit thresholds at byte address 4*i
//
// An accepted sample is held in the input register until the result register
// is free, then the five channels update and the flags land in the result
// register. One beat per cycle is taken sustained while the output is not
// stalled; the two registers form a simple stall-propagating pipeline.
// Reset (rst_ni low, asynchronous) clears flags, run counters and valid
// bits, and loads the threshold defaults. A stalled result holds both full stages.
module debounced_fault_monitor #(
  parameter int unsigned DebounceTicks   = dfm_pkg::DEBOUNCE_TICKS,
  parameter int unsigned OvpReleaseTicks = dfm_pkg::OVP_RELEASE_TICKS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dfm_stream_if.sink                 in_i,
  dfm_stream_if.source               out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dfm_pkg::APB_AW-1:0] paddr,
  input  logic [dfm_pkg::APB_DW-1:0] pwdata,
  output logic [dfm_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import dfm_pkg::*;

  cfg_t       cfg;
  in_item_t   smp_q;
  logic       smp_valid_q;
  out_item_t  res_q, res_d;
  logic       res_valid_q;
  logic       res_free;
  logic       advance;
  chan_cond_t cond [NUM_CHANS];
  logic [NUM_CHANS-1:0] flag_d;

  dfm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Result slot is free when empty or being drained this cycle
  assign res_free   = !res_valid_q || out_o.ready;
  assign advance    = smp_valid_q && res_free;
  assign in_i.ready = !smp_valid_q || res_free;

  // Sample register: hold the beat until the channels consume it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      smp_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      smp_q <= in_i.data;
    end
  end

  // Channel conditions, judged against the held sample
  always_comb begin
    cond[0].set_hit = (smp_q.ntc_raw > NTC_FAULT_HIGH) || (smp_q.ntc_raw < NTC_FAULT_LOW);
    cond[0].clr_hit = (smp_q.ntc_raw < NTC_OK_HIGH) && (smp_q.ntc_raw > NTC_OK_LOW);
    cond[1].set_hit = smp_q.temperature > cfg.hot_error_on;
    cond[1].clr_hit = smp_q.temperature < cfg.hot_error_off;
    cond[2].set_hit = smp_q.temperature > cfg.hot_warn_on;
    cond[2].clr_hit = smp_q.temperature < cfg.hot_warn_off;
    cond[3].set_hit = smp_q.out_voltage >= cfg.overvolt_on;
    cond[3].clr_hit = smp_q.out_voltage <= cfg.overvolt_off;
    cond[4].set_hit = smp_q.out_current >= cfg.overcurr_on;
    cond[4].clr_hit = smp_q.out_current <= cfg.overcurr_off;
  end

  // Over-voltage releases on its own, longer run; the rest share one length
  for (genvar c = 0; c < NUM_CHANS; c++) begin : g_chan
    dfm_channel #(
      .SetTicks   (DebounceTicks),
      .ClearTicks ((c == 3) ? OvpReleaseTicks : DebounceTicks)
    ) u_chan (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .cond_i    (cond[c]),
      .flag_d_o  (flag_d[c])
    );
  end

  always_comb begin
    res_d.sensor_fault = flag_d[0];
    res_d.hot_error    = flag_d[1];
    res_d.hot_warning  = flag_d[2];
    res_d.over_voltage = flag_d[3];
    res_d.over_current = flag_d[4];
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;
endmodule

FILE: rtl/dfm_apb_regs.sv
// APB-style threshold register file for the fault monitor.
// Depends on dfm_pkg.
module dfm_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dfm_pkg::APB_AW-1:0] paddr,
  input  logic [dfm_pkg::APB_DW-1:0] pwdata,
  output logic [dfm_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output dfm_pkg::cfg_t              cfg_o
);
  import dfm_pkg::*;

  cfg_t        cfg_q;
  logic [2:0]  idx;
  logic        wr_en;
  logic [REG_W-1:0] wval;
  logic [REG_W-1:0] rval;

  assign idx    = paddr[APB_AW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wval   = pwdata[REG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hot_error_on  <= THR_ON_RESET;
      cfg_q.hot_error_off <= THR_OFF_RESET;
      cfg_q.hot_warn_on   <= THR_ON_RESET;
      cfg_q.hot_warn_off  <= THR_OFF_RESET;
      cfg_q.overvolt_on   <= THR_ON_RESET;
      cfg_q.overvolt_off  <= THR_OFF_RESET;
      cfg_q.overcurr_on   <= THR_ON_RESET;
      cfg_q.overcurr_off  <= THR_OFF_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_HOT_ERR_ON:   cfg_q.hot_error_on  <= wval;
        REG_HOT_ERR_OFF:  cfg_q.hot_error_off <= wval;
        REG_HOT_WARN_ON:  cfg_q.hot_warn_on   <= wval;
        REG_HOT_WARN_OFF: cfg_q.hot_warn_off  <= wval;
        REG_OVOLT_ON:     cfg_q.overvolt_on   <= wval;
        REG_OVOLT_OFF:    cfg_q.overvolt_off  <= wval;
        REG_OCURR_ON:     cfg_q.overcurr_on   <= wval;
        REG_OCURR_OFF:    cfg_q.overcurr_off  <= wval;
        default:          cfg_q.overcurr_off  <= cfg_q.overcurr_off;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HOT_ERR_ON:   rval = cfg_q.hot_error_on;
      REG_HOT_ERR_OFF:  rval = cfg_q.hot_error_off;
      REG_HOT_WARN_ON:  rval = cfg_q.hot_warn_on;
      REG_HOT_WARN_OFF: rval = cfg_q.hot_warn_off;
      REG_OVOLT_ON:     rval = cfg_q.overvolt_on;
      REG_OVOLT_OFF:    rval = cfg_q.overvolt_off;
      REG_OCURR_ON:     rval = cfg_q.overcurr_on;
      REG_OCURR_OFF:    rval = cfg_q.overcurr_off;
      default:          rval = '0;
    endcase
  end

  assign prdata = {{(APB_DW-REG_W){1'b0}}, rval};
  assign cfg_o  = cfg_q;
endmodule

FILE: rtl/dfm_channel.sv
// One hysteresis flag with its debounce run counter.
// Depends on dfm_pkg.
module dfm_channel #(
  parameter int unsigned SetTicks   = dfm_pkg::DEBOUNCE_TICKS,
  parameter int unsigned ClearTicks = dfm_pkg::DEBOUNCE_TICKS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  dfm_pkg::chan_cond_t cond_i,
  output logic                flag_d_o
);
  import dfm_pkg::*;

  localparam logic [CNT_W:0] SetLim = (CNT_W+1)'(SetTicks);
  localparam logic [CNT_W:0] ClrLim = (CNT_W+1)'(ClearTicks);

  logic             flag_q, flag_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W:0]   cnt_inc;
  logic [CNT_W:0]   limit;
  logic             hit;

  assign cnt_inc = {1'b0, cnt_q} + (CNT_W+1)'(1);
  assign limit   = flag_q ? ClrLim : SetLim;
  assign hit     = flag_q ? cond_i.clr_hit : cond_i.set_hit;

  always_comb begin
    flag_d = flag_q;
    cnt_d  = cnt_q;
    if (advance_i) begin
      if (!hit) begin
        cnt_d = '0;                 // run broken: restart
      end else if (cnt_inc >= limit) begin
        cnt_d  = '0;
        flag_d = ~flag_q;           // run complete: toggle
      end else begin
        cnt_d = cnt_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      flag_q <= flag_d;
      cnt_q  <= cnt_d;
    end
  end

  assign flag_d_o = flag_d;
endmodule
